FILE: design/tci_pkg.sv
// ---------------------------------------------------------------------------
// tci_pkg
// Shared types and constants for the table curve interpolator.
// ---------------------------------------------------------------------------
package tci_pkg;

  localparam int MaxPointsDefault = 64;
  localparam int CfgWidth         = 7;
  localparam int CfgIndexWidth    = 1;

  localparam logic [0:0] OP_LOAD  = 1'b0;
  localparam logic [0:0] OP_QUERY = 1'b1;

  localparam logic [CfgIndexWidth-1:0] REG_POINTS_IN_USE = 1'b0;
  localparam logic [CfgIndexWidth-1:0] REG_INTERP_MODE   = 1'b1;

  localparam logic [1:0] POS_LOW    = 2'd0;
  localparam logic [1:0] POS_HIGH   = 2'd1;
  localparam logic [1:0] POS_INSIDE = 2'd2;

  typedef struct packed {
    logic [0:0]  opcode;
    logic [5:0]  point_index;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic [15:0] query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [17:0] interp_value;
    logic [1:0]         position_code;
  } out_item_t;

  // Query queued from the front to the back.
  typedef struct packed {
    logic [15:0] query_x;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENDS,       // read first point
    ST_ENDS2,      // read last point
    ST_SEARCH,     // walk segments
    ST_FETCH,      // read p0..p3
    ST_DIV,
    ST_LIN,
    ST_CR,
    ST_DONE
  } back_state_t;

endpackage

FILE: design/tci_ram.sv
// ---------------------------------------------------------------------------
// tci_ram
// Generic single write, single read RAM with registered read.
// ---------------------------------------------------------------------------
module tci_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/tci_front.sv
// ---------------------------------------------------------------------------
// tci_front
// Accepts items, writes loads to the table, queues queries for the back end.
// Two-entry queue toward the back end.
// ---------------------------------------------------------------------------
module tci_front #(
  parameter int MaxPoints = tci_pkg::MaxPointsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  tci_pkg::in_item_t            in_data,
  output logic                         we,
  output logic [$clog2(MaxPoints)-1:0] waddr,
  output logic [31:0]                  wdata,
  output logic                         job_valid,
  input  logic                         job_take,
  output tci_pkg::job_t                job,
  input  logic                         back_busy
);

  localparam int AW = $clog2(MaxPoints);

  tci_pkg::job_t q [2];
  logic [1:0]    count;
  logic          rd;
  logic          wr;
  logic          acc;
  logic          wr_head;

  // Loads wait for an empty queue and an idle back end, so they never
  // change the table under an earlier query.
  assign in_stall = (in_data.opcode == tci_pkg::OP_LOAD) ? ((count != 2'd0) || back_busy)
                                                          : (count == 2'd2);
  assign acc      = in_valid && !in_stall;
  assign wr       = acc && (in_data.opcode == tci_pkg::OP_QUERY);
  assign rd       = job_take && (count != 2'd0);
  assign wr_head  = wr && ((count == 2'd0) || (count == 2'd1 && rd));

  assign we    = acc && (in_data.opcode == tci_pkg::OP_LOAD) &&
                 ({26'd0, in_data.point_index} < 32'(MaxPoints));
  assign waddr = AW'(in_data.point_index);
  assign wdata = {in_data.point_y, in_data.point_x};

  assign job_valid = (count != 2'd0);
  assign job       = q[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
    if (wr_head) begin
      q[0].query_x <= in_data.query_x;
    end else if (rd) begin
      q[0] <= q[1];
    end
    if (wr && !wr_head) begin
      q[1].query_x <= in_data.query_x;
    end
  end

endmodule

FILE: design/tci_back.sv
// ---------------------------------------------------------------------------
// tci_back
// Runs one query: end checks, linear segment search over the table,
// 17-step restoring divide, then linear blend or Catmull-Rom Horner steps.
// ---------------------------------------------------------------------------
module tci_back #(
  parameter int MaxPoints = tci_pkg::MaxPointsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [6:0]                   points_in_use,
  input  logic                         interp_mode,
  input  logic                         job_valid,
  output logic                         job_take,
  input  tci_pkg::job_t                job,
  output logic [$clog2(MaxPoints)-1:0] raddr,
  input  logic [31:0]                  rdata,
  output logic                         out_valid,
  input  logic                         out_stall,
  output tci_pkg::out_item_t           out_data,
  output logic                         busy
);

  localparam int AW = $clog2(MaxPoints);
  localparam int CW = AW + 1;

  tci_pkg::back_state_t state, state_next;

  logic [15:0] q;
  logic [CW-1:0] n;
  logic [CW-1:0] idx;       // address issued last cycle
  logic [CW-1:0] seg;       // segment index i
  logic [15:0] prev_x, prev_y;
  logic [15:0] x1, x2;
  logic [15:0] y0, y1, y2, y3;
  logic [2:0]  sub;
  logic        rvalid;      // rdata holds entry idx
  logic [4:0]  dcnt;
  logic [16:0] rem;
  logic [16:0] quo;
  logic [15:0] den;
  logic [15:0] num;
  logic signed [19:0] ca, cb, cc, cd;
  logic signed [35:0] h;
  logic signed [53:0] prod;
  logic [1:0]  step;
  logic signed [35:0] res;
  logic [1:0]  code;
  logic [15:0] rx, ry;
  logic [CW-1:0] n_clamped;
  logic [17:0] rem_sh;
  logic signed [35:0] rnd;
  logic signed [19:0] coef;
  logic [33:0] lin;
  logic [15:0] diff;

  assign rx   = rdata[15:0];
  assign ry   = rdata[31:16];
  assign diff = q - x1;
  assign busy = (state != tci_pkg::ST_IDLE);

  always_comb begin
    if ({1'b0, points_in_use} < 8'd2) begin
      n_clamped = CW'(2);
    end else if ({25'd0, points_in_use} > 32'(MaxPoints)) begin
      n_clamped = CW'(MaxPoints);
    end else begin
      n_clamped = CW'(points_in_use);
    end
  end

  assign job_take = (state == tci_pkg::ST_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    case (state)
      tci_pkg::ST_IDLE:   if (job_valid && !out_valid) state_next = tci_pkg::ST_ENDS;
      tci_pkg::ST_ENDS:   if (rvalid) state_next = tci_pkg::ST_ENDS2;
      tci_pkg::ST_ENDS2: begin
        if (rvalid) begin
          if (q <= prev_x || q > rx) state_next = tci_pkg::ST_DONE;
          else state_next = tci_pkg::ST_SEARCH;
        end
      end
      tci_pkg::ST_SEARCH: begin
        if (rvalid && idx != '0) begin
          if (prev_x <= q && q <= rx) begin
            state_next = (rx <= prev_x) ? tci_pkg::ST_DONE : tci_pkg::ST_FETCH;
          end else if (idx == n - CW'(1)) begin
            state_next = tci_pkg::ST_DONE;
          end
        end
      end
      tci_pkg::ST_FETCH:  if (rvalid && sub == 3'd3) state_next = tci_pkg::ST_DIV;
      tci_pkg::ST_DIV: begin
        if (dcnt == 5'd17) begin
          state_next = interp_mode ? tci_pkg::ST_CR : tci_pkg::ST_LIN;
        end
      end
      tci_pkg::ST_LIN:    state_next = tci_pkg::ST_DONE;
      tci_pkg::ST_CR:     if (step == 2'd3 && sub[0]) state_next = tci_pkg::ST_DONE;
      tci_pkg::ST_DONE:   state_next = tci_pkg::ST_IDLE;
      default:            state_next = tci_pkg::ST_IDLE;
    endcase
  end

  // Read address: chosen from the state and the sub-step counter.
  always_comb begin
    case (state)
      tci_pkg::ST_FETCH: begin
        case (sub)
          3'd0:    raddr = AW'((seg != '0) ? seg - CW'(1) : seg);
          3'd1:    raddr = AW'(seg);
          3'd2:    raddr = AW'(seg + CW'(1));
          default: raddr = AW'((seg + CW'(2) < n) ? seg + CW'(2) : seg + CW'(1));
        endcase
      end
      default: raddr = AW'(idx);
    endcase
  end

  assign rem_sh = {rem, num[15]};
  assign coef = (step == 2'd0) ? cb : (step == 2'd1) ? cc : cd;
  assign rnd  = 36'((prod + 54'sd32768) >>> 16);
  assign lin  = 34'(y1) * 34'(17'h10000 - quo) + 34'(y2) * 34'(quo) + 34'd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tci_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == tci_pkg::ST_DONE) out_valid <= 1'b1;
    end

    case (state)
      tci_pkg::ST_IDLE: begin
        q      <= job.query_x;
        n      <= n_clamped;
        idx    <= '0;
        rvalid <= 1'b0;
      end
      tci_pkg::ST_ENDS: begin
        rvalid <= !rvalid;
        if (rvalid) begin
          prev_x <= rx;
          prev_y <= ry;
          idx    <= n - CW'(1);
        end
      end
      tci_pkg::ST_ENDS2: begin
        rvalid <= !rvalid;
        if (rvalid) begin
          if (q <= prev_x) begin
            res <= 36'(prev_y); code <= tci_pkg::POS_LOW;
          end else begin
            res <= 36'(ry); code <= tci_pkg::POS_HIGH;
          end
          y3  <= ry;                // last y, for the not-found case
          idx <= '0;
        end
      end
      tci_pkg::ST_SEARCH: begin
        rvalid <= !rvalid;
        if (rvalid) begin
          prev_x <= rx;
          prev_y <= ry;
          if (idx != '0 && prev_x <= q && q <= rx) begin
            seg  <= idx - CW'(1);
            x1   <= prev_x;
            x2   <= rx;
            code <= tci_pkg::POS_INSIDE;
            res  <= 36'(prev_y);
            sub  <= 3'd0;
          end else if (idx != '0 && idx == n - CW'(1)) begin
            res  <= 36'(y3);
            code <= tci_pkg::POS_HIGH;
          end else begin
            idx <= idx + CW'(1);
          end
        end
      end
      tci_pkg::ST_FETCH: begin
        rvalid <= !rvalid;
        if (rvalid) begin
          case (sub)
            3'd0:    y0 <= ry;
            3'd1:    y1 <= ry;
            3'd2:    y2 <= ry;
            default: y3 <= ry;
          endcase
          sub <= sub + 3'd1;
        end
        // quotient bits above 16 are zero, so start from (q-x1)>>1
        num  <= {diff[0], 15'd0};
        rem  <= {2'b00, diff[15:1]};
        den  <= x2 - x1;
        quo  <= '0;
        dcnt <= '0;
      end
      tci_pkg::ST_DIV: begin
        // (q-x1)<<16 / den: low 17 dividend bits shifted in, MSB first
        if (dcnt != 5'd17) begin
          dcnt <= dcnt + 5'd1;
          num  <= {num[14:0], 1'b0};
          if (rem_sh >= {2'b00, den}) begin
            rem <= 17'(rem_sh - {2'b00, den});
            quo <= {quo[15:0], 1'b1};
          end else begin
            rem <= rem_sh[16:0];
            quo <= {quo[15:0], 1'b0};
          end
        end else begin
          if (quo > 17'h10000) quo <= 17'h10000;
        end
        ca   <= 20'sd3 * $signed({4'd0, y1}) - $signed({4'd0, y0})
              - 20'sd3 * $signed({4'd0, y2}) + $signed({4'd0, y3});
        cb   <= 20'sd2 * $signed({4'd0, y0}) - 20'sd5 * $signed({4'd0, y1})
              + 20'sd4 * $signed({4'd0, y2}) - $signed({4'd0, y3});
        cc   <= $signed({4'd0, y2}) - $signed({4'd0, y0});
        cd   <= 20'sd2 * $signed({4'd0, y1});
        step <= '0;
        sub  <= '0;
      end
      tci_pkg::ST_LIN: begin
        res <= 36'(lin[33:16]);
      end
      tci_pkg::ST_CR: begin
        // even sub: multiply; odd sub: round and add next coefficient
        sub <= {2'b00, ~sub[0]};
        if (!sub[0]) begin
          prod <= ((step == 2'd0) ? 54'(ca) <<< 16 : 54'(h)) * $signed({37'd0, quo});
        end else begin
          h <= rnd + (36'(coef) <<< 16);
          if (step != 2'd3) step <= step + 2'd1;
        end
        if (step == 2'd3 && sub[0]) begin
          res <= 36'((36'(h) + 36'sd65536) >>> 17);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_data.position_code = code;
    if (res < -36'sd131072)      out_data.interp_value = -18'sd131072;
    else if (res > 36'sd131071)  out_data.interp_value = 18'sd131071;
    else                         out_data.interp_value = res[17:0];
  end

endmodule

FILE: design/table_curve_interpolator_unit.sv
// ---------------------------------------------------------------------------
// table_curve_interpolator_unit
// Table based linear / Catmull-Rom curve interpolator.
// ---------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_stall/in_data): load transactions write one
//     point to the table; query transactions ask for y at query_x.
//   out channel (out_valid/out_stall/out_data): one transaction per query,
//     in query order. Loads give nothing.
//   cfg port: cfg_we/cfg_index/cfg_data, write only, while idle.
// Flow: a query clamped at a table end goes from the end checks straight
//   to out_valid; one inside also walks the segments, runs the bit-serial
//   divide and then the Catmull-Rom or linear step. The segment walk
//   through the single table read port sets the worst case. Items run one
//   at a time in the back end; the front takes up to two queued queries
//   meanwhile.
// A load stalls until queued queries and the one in the back end are done.
// Reset clears the queue and out_valid; points_in_use returns to 2
//   and interp_mode to Catmull-Rom. Table content is undefined until loaded.
// A stalled result holds; the back end then waits before the next query.
// ---------------------------------------------------------------------------
module table_curve_interpolator_unit #(
  parameter int MaxPoints = tci_pkg::MaxPointsDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tci_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tci_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [tci_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [tci_pkg::CfgWidth-1:0]      cfg_data
);

  localparam int AW = $clog2(MaxPoints);

  logic [6:0]    points_in_use;
  logic          interp_mode;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic          job_valid, job_take;
  tci_pkg::job_t job;
  logic          back_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= 7'd2;
      interp_mode   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        tci_pkg::REG_POINTS_IN_USE: points_in_use <= cfg_data;
        tci_pkg::REG_INTERP_MODE:   interp_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tci_front #(.MaxPoints(MaxPoints)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .we, .waddr, .wdata, .job_valid, .job_take, .job, .back_busy
  );

  tci_ram #(.Width(32), .Depth(MaxPoints)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  tci_back #(.MaxPoints(MaxPoints)) u_back (
    .clk, .rst, .points_in_use, .interp_mode, .job_valid, .job_take, .job,
    .raddr, .rdata, .out_valid, .out_stall, .out_data, .busy(back_busy)
  );

endmodule

FILE: test/tci_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tci_checker
// Watches the input, output and config ports of the curve interpolator and
// keeps a shadow table and config. Each accepted query gets a predicted
// result. Each output transaction is compared field by field with the oldest
// prediction.
// ---------------------------------------------------------------------------
module tci_checker
  import tci_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  in_item_t                 in_data,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]      cfg_data,
  output int                       errors,
  output int                       outstanding
);

  logic [31:0] curve_tbl [MaxPointsDefault];  // y in 31:16, x in 15:0
  logic [6:0]  pts_cfg;
  logic        mode_cfg;
  out_item_t   expected_curve_q [$];

  initial begin
    errors      = 0;
    outstanding = 0;
    foreach (curve_tbl[k]) curve_tbl[k] = '0;
  end

  // floor((v + 2^15) / 2^16)
  function automatic longint rnd16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic out_item_t interpolate_curve(logic [15:0] q);
    int        n;
    int        seg;
    int        i0;
    int        i3;
    bit        found;
    longint    x1, x2, t, v;
    longint    p0, p1, p2, p3, ca, cb, cc, cd, h;
    logic [1:0] code;
    out_item_t r;
    n     = pts_cfg;
    found = 0;
    seg   = 0;
    if (n < 2) n = 2;
    if (n > MaxPointsDefault) n = MaxPointsDefault;
    if (q <= curve_tbl[0][15:0]) begin
      v    = curve_tbl[0][31:16];
      code = POS_LOW;
    end else if (q > curve_tbl[n-1][15:0]) begin
      v    = curve_tbl[n-1][31:16];
      code = POS_HIGH;
    end else begin
      for (int i = 0; i < n - 1; i++) begin
        if (curve_tbl[i][15:0] <= q && q <= curve_tbl[i+1][15:0]) begin
          found = 1;
          seg   = i;
          break;
        end
      end
      if (!found) begin
        v    = curve_tbl[n-1][31:16];
        code = POS_HIGH;
      end else begin
        code = POS_INSIDE;
        x1   = curve_tbl[seg][15:0];
        x2   = curve_tbl[seg+1][15:0];
        if (x2 <= x1) begin
          v = curve_tbl[seg][31:16];
        end else begin
          t = ((longint'(q) - x1) << 16) / (x2 - x1);
          if (t > 65536) t = 65536;
          p1 = curve_tbl[seg][31:16];
          p2 = curve_tbl[seg+1][31:16];
          if (mode_cfg == 1'b0) begin
            v = (p1 * (65536 - t) + p2 * t + 32768) >>> 16;
          end else begin
            i0 = (seg > 0) ? seg - 1 : seg;
            i3 = (seg + 2 < n) ? seg + 2 : seg + 1;
            p0 = curve_tbl[i0][31:16];
            p3 = curve_tbl[i3][31:16];
            ca = 3 * p1 - p0 - 3 * p2 + p3;
            cb = 2 * p0 - 5 * p1 + 4 * p2 - p3;
            cc = p2 - p0;
            cd = 2 * p1;
            h  = ca <<< 16;
            h  = rnd16(h * t) + (cb <<< 16);
            h  = rnd16(h * t) + (cc <<< 16);
            h  = rnd16(h * t) + (cd <<< 16);
            v  = (h + 65536) >>> 17;
          end
        end
      end
    end
    if (v < -131072) v = -131072;
    if (v > 131071) v = 131071;
    r.interp_value  = v[17:0];
    r.position_code = code;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst) begin
      expected_curve_q.delete();
      pts_cfg  = 7'd2;
      mode_cfg = 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POINTS_IN_USE: pts_cfg  = cfg_data;
          REG_INTERP_MODE:   mode_cfg = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_data.opcode == OP_LOAD) begin
          curve_tbl[in_data.point_index] = {in_data.point_y, in_data.point_x};
        end else begin
          expected_curve_q.push_back(interpolate_curve(in_data.query_x));
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_curve_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual value=%0d code=%0d",
                   $time, out_data.interp_value, out_data.position_code);
        end else begin
          exp_r = expected_curve_q.pop_front();
          if (out_data.interp_value !== exp_r.interp_value) begin
            errors++;
            $display("%0t: interp_value mismatch: expected %0d, actual %0d",
                     $time, exp_r.interp_value, out_data.interp_value);
          end
          if (out_data.position_code !== exp_r.position_code) begin
            errors++;
            $display("%0t: position_code mismatch: expected %0d, actual %0d",
                     $time, exp_r.position_code, out_data.position_code);
          end
        end
      end
    end
    outstanding = expected_curve_q.size();
  end

endmodule

FILE: test/table_curve_interpolator_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// table_curve_interpolator_unit_tb
// Stimulus and verdict for the curve interpolator. The run works in phases:
// each phase sets the point count and the interpolation mode while the block
// is idle, loads a fresh table, then sends queries mixed with table rewrites.
// Prediction and comparison happen in tci_checker.
// ---------------------------------------------------------------------------
module table_curve_interpolator_unit_tb;
  import tci_pkg::*;

  localparam int TotalItems = 1750;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  in_item_t                 in_data;
  logic                     out_valid;
  logic                     out_stall;
  out_item_t                out_data;
  logic                     cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgWidth-1:0]      cfg_data;
  int                       errors;
  int                       outstanding;

  // Stimulus side bookkeeping: x values the TB believes are in the table,
  // the effective point count, and the number of items sent so far.
  logic [15:0] shadow_x [MaxPointsDefault];
  int          active_pts;
  int          items_sent;
  bit          calm;  // no idling on either side while set

  table_curve_interpolator_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tci_checker curve_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver backpressure: about 17% stall, none during the calm stretch.
  initial out_stall = 1'b0;
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 17);
  end

  // Hard stop.
  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Send one transaction. Entered and left at a falling edge; in_valid stays
  // high on return so back-to-back sends never drop it within one step.
  task automatic send_item(in_item_t item);
    if (!calm && $urandom_range(99) < 17) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic load_point(int slot, logic [15:0] x, logic [15:0] y);
    in_item_t item;
    item             = '0;
    item.opcode      = OP_LOAD;
    item.point_index = slot[5:0];
    item.point_x     = x;
    item.point_y     = y;
    item.query_x     = 16'($urandom);  // don't-care field, still toggled
    shadow_x[slot]   = x;
    send_item(item);
  endtask

  task automatic query_at(logic [15:0] q);
    in_item_t item;
    item             = '0;
    item.opcode      = OP_QUERY;
    item.point_index = 6'($urandom);
    item.point_x     = 16'($urandom);
    item.point_y     = 16'($urandom);
    item.query_x     = q;
    send_item(item);
  endtask

  // Drop valid, wait for all results, then give a possible load in flight
  // time to retire before the block is touched again.
  task automatic drain;
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgWidth-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Count register written raw: 0/1 act as 2, above the table acts as 64.
  task automatic set_mode(int pts, bit cubic);
    drain();
    write_reg(REG_POINTS_IN_USE, pts[6:0]);
    write_reg(REG_INTERP_MODE, {6'($urandom), cubic});
    active_pts = (pts < 2) ? 2 : ((pts > MaxPointsDefault) ? MaxPointsDefault : pts);
  endtask

  // Fresh ascending table over the active points. Alternating extremes in y
  // push the cubic into overshoot and saturation.
  task automatic load_curve(bit zigzag);
    int step;
    logic [15:0] x, y;
    step = 65536 / active_pts;
    for (int i = 0; i < active_pts; i++) begin
      x = 16'(i * step + $urandom_range(0, step - 1));
      if (i == 0 && $urandom_range(3) == 0) x = 16'h0000;
      if (i == active_pts - 1 && $urandom_range(3) == 0) x = 16'hFFFF;
      y = zigzag ? ((i % 2) ? 16'hFFFF : 16'h0000) : 16'($urandom);
      load_point(i, x, y);
    end
  endtask

  function automatic logic [15:0] pick_query();
    int sel;
    int lo, hi;
    sel = $urandom_range(99);
    lo  = shadow_x[0];
    hi  = shadow_x[active_pts-1];
    if (sel < 50 && lo < hi) return 16'($urandom_range(lo, hi));
    if (sel < 65) return shadow_x[$urandom_range(0, active_pts - 1)];
    if (sel < 72) return 16'(lo + 1);
    if (sel < 78) return (sel < 75) ? 16'h0000 : 16'hFFFF;
    return 16'($urandom);
  endfunction

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    calm       = 1'b0;
    items_sent = 0;
    active_pts = 2;
    foreach (shadow_x[k]) shadow_x[k] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset defaults (two points, Catmull-Rom) over the full range.
    load_point(0, 16'h0000, 16'hFFFF);
    load_point(1, 16'hFFFF, 16'h0000);
    query_at(16'h0000);
    query_at(16'hFFFF);
    query_at(16'h8000);
    query_at(16'h0001);
    // Narrow segment: below, at the first x, above the last x, inside, at the last x.
    load_point(0, 16'd100, 16'h0000);
    load_point(1, 16'd200, 16'hFFFF);
    query_at(16'd50);
    query_at(16'd100);
    query_at(16'd300);
    query_at(16'd150);
    query_at(16'd200);
    load_point(63, 16'hFFFF, 16'hFFFF);  // top slot, out of use
    // Linear mode on the same segment, with a raw count of zero.
    set_mode(0, 1'b0);
    query_at(16'd150);
    query_at(16'd101);
    query_at(16'd199);
    // Four points in a zigzag: cubic overshoot at both table ends.
    set_mode(4, 1'b1);
    load_point(0, 16'd0,  16'h0000);
    load_point(1, 16'd10, 16'hFFFF);
    load_point(2, 16'd20, 16'h0000);
    load_point(3, 16'd30, 16'hFFFF);
    query_at(16'd5);
    query_at(16'd15);
    query_at(16'd25);

    // Random phases. Mostly small tables, occasionally the count extremes.
    while (items_sent < TotalItems) begin
      int sel;
      int pts;
      int burst;
      sel = $urandom_range(99);
      if (sel < 8) pts = $urandom_range(0, 1);
      else if (sel < 16) pts = MaxPointsDefault;
      else if (sel < 21) pts = $urandom_range(MaxPointsDefault + 1, 127);
      else pts = $urandom_range(2, 12);
      set_mode(pts, 1'($urandom));
      load_curve($urandom_range(4) == 0);
      // One calm stretch with no idling on either side.
      calm  = (items_sent > 600 && items_sent < 900);
      burst = $urandom_range(60, 150);
      for (int k = 0; k < burst; k++) begin
        sel = $urandom_range(99);
        if (sel < 82) begin
          query_at(pick_query());
        end else if (sel < 92) begin
          // Rewrite y only: table stays ordered.
          int slot;
          slot = $urandom_range(0, active_pts - 1);
          load_point(slot, shadow_x[slot], 16'($urandom));
        end else if (sel < 97) begin
          // Noise: any slot, any x. May leave the table unordered.
          load_point($urandom_range(0, MaxPointsDefault - 1), 16'($urandom),
                     16'($urandom));
        end else begin
          // Hold off until the block has emptied, then carry on.
          drain();
        end
      end
      calm = 1'b0;
    end

    drain();
    if (errors == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
